@@ src/rgbhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV hexcone converter.
// Used by rgbhsv_div and rgb_to_hsv_converter; no dependencies.
package rgbhsv_pkg;

    // Field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 9;

    // Hue constants in 1/64 degree units
    localparam logic [HUE_W-1:0] HUE_SIXTY     = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL      = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_RED_OFS   = 15'd0;
    localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 15'd15360;

    // Saturation numerator is spread * 256
    localparam int SAT_SHIFT = 8;
    localparam int SAT_NUM_W = CH_W + SAT_SHIFT;

    // Divider geometry: numerator up to 255*3840, quotient at most 3840
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = CH_W;
    localparam int DIV_QUO_W = 12;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Per-pixel data that rides alongside the divider
    typedef struct packed {
        t_sector         sector;
        logic            neg;
        logic            gray;
        logic            black;
        logic [CH_W-1:0] mx;
    } t_side;

endpackage

@@ src/rgbhsv_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rgbhsv_pkg for widths and the sideband struct.
module rgbhsv_div
    import rgbhsv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_side                i_side,
    input  logic [DIV_NUM_W-1:0] i_hue_num,
    input  logic [DIV_DEN_W-1:0] i_hue_den,
    input  logic [DIV_NUM_W-1:0] i_sat_num,
    input  logic [DIV_DEN_W-1:0] i_sat_den,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [DIV_QUO_W-1:0] o_hue_quo,
    output logic [DIV_QUO_W-1:0] o_sat_quo
);

    // Stage registers, index k holds the result of stage k
    logic                 r_vld   [DIV_QUO_W];
    t_side                r_side  [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] r_rem_h [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] r_den_h [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] r_quo_h [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] r_rem_s [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] r_den_s [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] r_quo_s [DIV_QUO_W];

    for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_stage
        localparam int SH = DIV_QUO_W - 1 - k;

        logic                 w_vld;
        t_side                w_side;
        logic [DIV_NUM_W-1:0] w_rem_h, w_rem_s;
        logic [DIV_DEN_W-1:0] w_den_h, w_den_s;
        logic [DIV_QUO_W-1:0] w_quo_h, w_quo_s;
        logic [DIV_NUM_W-1:0] w_trial_h, w_trial_s;
        logic [DIV_NUM_W-1:0] n_rem_h, n_rem_s;
        logic [DIV_QUO_W-1:0] n_quo_h, n_quo_s;

        // Stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign w_vld   = i_valid;
            assign w_side  = i_side;
            assign w_rem_h = i_hue_num;
            assign w_den_h = i_hue_den;
            assign w_quo_h = '0;
            assign w_rem_s = i_sat_num;
            assign w_den_s = i_sat_den;
            assign w_quo_s = '0;
        end else begin : g_next
            assign w_vld   = r_vld[k-1];
            assign w_side  = r_side[k-1];
            assign w_rem_h = r_rem_h[k-1];
            assign w_den_h = r_den_h[k-1];
            assign w_quo_h = r_quo_h[k-1];
            assign w_rem_s = r_rem_s[k-1];
            assign w_den_s = r_den_s[k-1];
            assign w_quo_s = r_quo_s[k-1];
        end

        // Compare and subtract the divisor aligned to this quotient bit
        always_comb begin
            w_trial_h = DIV_NUM_W'(w_den_h) << SH;
            w_trial_s = DIV_NUM_W'(w_den_s) << SH;
            if (w_rem_h >= w_trial_h) begin
                n_rem_h = w_rem_h - w_trial_h;
                n_quo_h = {w_quo_h[DIV_QUO_W-2:0], 1'b1};
            end else begin
                n_rem_h = w_rem_h;
                n_quo_h = {w_quo_h[DIV_QUO_W-2:0], 1'b0};
            end
            if (w_rem_s >= w_trial_s) begin
                n_rem_s = w_rem_s - w_trial_s;
                n_quo_s = {w_quo_s[DIV_QUO_W-2:0], 1'b1};
            end else begin
                n_rem_s = w_rem_s;
                n_quo_s = {w_quo_s[DIV_QUO_W-2:0], 1'b0};
            end
        end

        // Valid bit is control, cleared by reset
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        // Payload registers
        always_ff @(posedge i_clk) begin
            r_side[k]  <= w_side;
            r_rem_h[k] <= n_rem_h;
            r_den_h[k] <= w_den_h;
            r_quo_h[k] <= n_quo_h;
            r_rem_s[k] <= n_rem_s;
            r_den_s[k] <= w_den_s;
            r_quo_s[k] <= n_quo_s;
        end
    end

    assign o_valid   = r_vld[DIV_QUO_W-1];
    assign o_side    = r_side[DIV_QUO_W-1];
    assign o_hue_quo = r_quo_h[DIV_QUO_W-1];
    assign o_sat_quo = r_quo_s[DIV_QUO_W-1];

endmodule

@@ src/rgb_to_hsv_converter.sv @@
// RGB to HSV hexcone converter, top level. Each pixel passes through the input,
// compare and scale registers, 12 divider stages and the output register.
// Throughput is one pixel every cycle because every stage is
// pipelined, so busy stays low. Synchronous active-low reset clears all valid
// bits; the receiver takes every strobe, so nothing ever stalls.
// Depends on rgbhsv_pkg and rgbhsv_div.
module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CH_W-1:0]  i_red,
    input  logic [CH_W-1:0]  i_green,
    input  logic [CH_W-1:0]  i_blue,
    output logic             o_busy,
    output logic             o_strobe,
    output logic [HUE_W-1:0] o_hue,
    output logic [SAT_W-1:0] o_saturation,
    output logic [CH_W-1:0]  o_brightness
);

    // Pipeline never stalls
    assign o_busy = 1'b0;

    // ---------------- stage 1: input register ----------------
    logic            r_s1_vld;
    logic [CH_W-1:0] r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_r <= i_red;
        r_s1_g <= i_green;
        r_s1_b <= i_blue;
    end

    // ---------------- stage 2: max, min, sector, difference ----------------
    logic            r_s2_vld;
    t_side           r_s2_side;
    logic [CH_W-1:0] r_s2_spread, r_s2_absdiff;

    logic [CH_W-1:0] w_mx, w_mn;
    t_side           n_s2_side;
    logic [CH_W-1:0] n_s2_spread, n_s2_absdiff;
    logic [CH_W-1:0] w_pos, w_negv;

    always_comb begin
        w_mx = r_s1_r;
        if (r_s1_g > w_mx) begin
            w_mx = r_s1_g;
        end
        if (r_s1_b > w_mx) begin
            w_mx = r_s1_b;
        end
        w_mn = r_s1_r;
        if (r_s1_g < w_mn) begin
            w_mn = r_s1_g;
        end
        if (r_s1_b < w_mn) begin
            w_mn = r_s1_b;
        end

        // Red wins ties, then green, then blue
        if (r_s1_r == w_mx) begin
            n_s2_side.sector = SEC_RED;
            w_pos  = r_s1_g;
            w_negv = r_s1_b;
        end else if (r_s1_g == w_mx) begin
            n_s2_side.sector = SEC_GREEN;
            w_pos  = r_s1_b;
            w_negv = r_s1_r;
        end else begin
            n_s2_side.sector = SEC_BLUE;
            w_pos  = r_s1_r;
            w_negv = r_s1_g;
        end

        // Magnitude and sign of the channel difference
        n_s2_side.neg = w_pos < w_negv;
        if (n_s2_side.neg) begin
            n_s2_absdiff = w_negv - w_pos;
        end else begin
            n_s2_absdiff = w_pos - w_negv;
        end

        n_s2_spread      = w_mx - w_mn;
        n_s2_side.gray   = w_mx == w_mn;
        n_s2_side.black  = w_mx == '0;
        n_s2_side.mx     = w_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_side    <= n_s2_side;
        r_s2_spread  <= n_s2_spread;
        r_s2_absdiff <= n_s2_absdiff;
    end

    // ---------------- stage 3: scale numerators ----------------
    logic                 r_s3_vld;
    t_side                r_s3_side;
    logic [CH_W-1:0]      r_s3_spread;
    logic [DIV_NUM_W-1:0] r_s3_hue_num;
    logic [DIV_NUM_W-1:0] r_s3_sat_num;

    logic [DIV_NUM_W-1:0] n_s3_hue_num;
    logic [DIV_NUM_W-1:0] n_s3_sat_num;

    // |diff| * 3840 and spread * 256
    always_comb begin
        n_s3_hue_num = DIV_NUM_W'(r_s2_absdiff) * DIV_NUM_W'(HUE_SIXTY);
        n_s3_sat_num = DIV_NUM_W'({r_s2_spread, {SAT_SHIFT{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side    <= r_s2_side;
        r_s3_spread  <= r_s2_spread;
        r_s3_hue_num <= n_s3_hue_num;
        r_s3_sat_num <= n_s3_sat_num;
    end

    // ---------------- divider stages ----------------
    logic                 w_dv_vld;
    t_side                w_dv_side;
    logic [DIV_QUO_W-1:0] w_dv_hue_quo;
    logic [DIV_QUO_W-1:0] w_dv_sat_quo;

    rgbhsv_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s3_vld),
        .i_side    (r_s3_side),
        .i_hue_num (r_s3_hue_num),
        .i_hue_den (r_s3_spread),
        .i_sat_num (r_s3_sat_num),
        .i_sat_den (r_s3_side.mx),
        .o_valid   (w_dv_vld),
        .o_side    (w_dv_side),
        .o_hue_quo (w_dv_hue_quo),
        .o_sat_quo (w_dv_sat_quo)
    );

    // ---------------- output stage: sector offset, wrap, special cases ------
    logic             r_out_vld;
    logic [HUE_W-1:0] r_out_hue;
    logic [SAT_W-1:0] r_out_sat;
    logic [CH_W-1:0]  r_out_val;

    logic [HUE_W-1:0]        w_base;
    logic signed [HUE_W:0]   w_h;
    logic [HUE_W-1:0]        n_out_hue;
    logic [SAT_W-1:0]        n_out_sat;

    always_comb begin
        case (w_dv_side.sector)
            SEC_RED:   w_base = HUE_RED_OFS;
            SEC_GREEN: w_base = HUE_GREEN_OFS;
            SEC_BLUE:  w_base = HUE_BLUE_OFS;
            default:   w_base = HUE_RED_OFS;
        endcase

        // Quotient is truncated toward zero, then signed
        if (w_dv_side.neg) begin
            w_h = $signed({1'b0, w_base}) - $signed((HUE_W + 1)'(w_dv_hue_quo));
        end else begin
            w_h = $signed({1'b0, w_base}) + $signed((HUE_W + 1)'(w_dv_hue_quo));
        end
        if (w_h < 0) begin
            w_h = w_h + $signed({1'b0, HUE_FULL});
        end

        if (w_dv_side.gray) begin
            n_out_hue = '0;
        end else begin
            n_out_hue = w_h[HUE_W-1:0];
        end

        if (w_dv_side.black) begin
            n_out_sat = '0;
        end else begin
            n_out_sat = w_dv_sat_quo[SAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hue <= n_out_hue;
        r_out_sat <= n_out_sat;
        r_out_val <= w_dv_side.mx;
    end

    assign o_strobe     = r_out_vld;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_sat;
    assign o_brightness = r_out_val;

    // ---------------- checks ----------------
    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue < HUE_FULL))
        else $error("hue out of range");

    a_sat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_saturation <= SAT_W'(256)))
        else $error("saturation above full scale");

    a_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_brightness == '0) |-> (o_hue == '0 && o_saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

@@ verif/rgb_to_hsv_converter_tb.sv @@
// Self-checking testbench for rgb_to_hsv_converter: directed corner pixels
// plus weighted random pixels, checked against an in-bench HSV predictor.
// Depends on rgbhsv_pkg and the converter RTL (rgb_to_hsv_converter, rgbhsv_div).
module rgb_to_hsv_converter_tb;
    import rgbhsv_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 6;
    localparam int RAND_PIXELS = 400;
    localparam int DRAIN_WAIT  = 24;       // comfortably past the converter pipeline
    localparam int CYCLE_LIMIT = 200000;

    // One converted pixel as seen on the result ports
    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [CH_W-1:0]  value;
    } t_hsv;

    // Expected HSV for one pixel, hexcone model with integer arithmetic
    function automatic t_hsv predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b);
        t_hsv    res;
        t_sector sector;
        int      mx;
        int      mn;
        int      spread;
        int      diff;
        int      base;
        int      h;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        spread = mx - mn;

        res.value = mx[CH_W-1:0];
        res.sat   = (mx == 0) ? '0 : SAT_W'((spread * 256) / mx);

        // Ties go to red first, then green
        if (mx == int'(r))      sector = SEC_RED;
        else if (mx == int'(g)) sector = SEC_GREEN;
        else                    sector = SEC_BLUE;

        case (sector)
            SEC_RED: begin
                diff = int'(g) - int'(b);
                base = int'(HUE_RED_OFS);
            end
            SEC_GREEN: begin
                diff = int'(b) - int'(r);
                base = int'(HUE_GREEN_OFS);
            end
            default: begin
                diff = int'(r) - int'(g);
                base = int'(HUE_BLUE_OFS);
            end
        endcase

        // Gray pixels have no hue; division truncates toward zero
        if (spread == 0) begin
            h = 0;
        end else begin
            h = base + (diff * int'(HUE_SIXTY)) / spread;
            if (h < 0) h += int'(HUE_FULL);
        end
        res.hue = h[HUE_W-1:0];
        return res;
    endfunction

    // Scoreboard: holds expected HSV results in request order
    class hsv_scoreboard;
        t_hsv pending_hsv[$];
        int   errors;
        int   requests;
        int   results;
        int   gray_seen;
        int   black_seen;

        function new();
            errors     = 0;
            requests   = 0;
            results    = 0;
            gray_seen  = 0;
            black_seen = 0;
        endfunction

        function void note_request(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                   logic [CH_W-1:0] b);
            t_hsv exp_hsv;
            exp_hsv = predict_hsv(r, g, b);
            pending_hsv.push_back(exp_hsv);
            requests++;
            if (r == g && g == b) gray_seen++;
            if (exp_hsv.value == 0) black_seen++;
        endfunction

        function void check_result(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                   logic [CH_W-1:0] value);
            t_hsv exp_hsv;
            results++;
            if (pending_hsv.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hue=%0d sat=%0d value=%0d",
                         $time, hue, sat, value);
                return;
            end
            exp_hsv = pending_hsv.pop_front();
            if (hue !== exp_hsv.hue) begin
                errors++;
                $display("%0t: hue mismatch expected %0d actual %0d",
                         $time, exp_hsv.hue, hue);
            end
            if (sat !== exp_hsv.sat) begin
                errors++;
                $display("%0t: saturation mismatch expected %0d actual %0d",
                         $time, exp_hsv.sat, sat);
            end
            if (value !== exp_hsv.value) begin
                errors++;
                $display("%0t: brightness mismatch expected %0d actual %0d",
                         $time, exp_hsv.value, value);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic [CH_W-1:0]  i_red   = '0;
    logic [CH_W-1:0]  i_green = '0;
    logic [CH_W-1:0]  i_blue  = '0;
    logic             o_busy;
    logic             o_strobe;
    logic [HUE_W-1:0] o_hue;
    logic [SAT_W-1:0] o_saturation;
    logic [CH_W-1:0]  o_brightness;

    hsv_scoreboard sb = new();
    int            cycle_count = 0;
    bit            no_gaps = 1'b0;

    rgb_to_hsv_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_hue       (o_hue),
        .o_saturation(o_saturation),
        .o_brightness(o_brightness)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Monitor: note accepted requests and check every strobed result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_request(i_red, i_green, i_blue);
            if (o_strobe) sb.check_result(o_hue, o_saturation, o_brightness);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // Idle length between requests: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 50) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 95) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Present one request, hold it until accepted, then maybe idle
    task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b);
        int gap;
        i_start <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One channel value biased toward the ends of the range
    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return CH_W'($urandom_range(3));
            3:       return CH_W'($urandom_range(255, 252));
            default: return CH_W'($urandom);
        endcase
    endfunction

    // Random pixels: plain random, channel ties, grays and extreme values
    task automatic random_pixels(int count);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            // Bursts of back-to-back requests now and then
            if (n % 50 == 0) no_gaps = ($urandom_range(2) == 0);
            r = CH_W'($urandom);
            g = CH_W'($urandom);
            b = CH_W'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3: ;
                4: g = r;                      // red and green tie
                5: b = g;                      // green and blue tie
                6: b = r;                      // red and blue tie
                7: begin                       // gray
                    g = r;
                    b = r;
                end
                default: begin
                    r = pick_channel();
                    g = pick_channel();
                    b = pick_channel();
                end
            endcase
            send_pixel(r, g, b);
        end
        no_gaps = 1'b0;
    endtask

    // Stimulus and end of run
    initial begin
        int waited;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: black, grays, primaries, ties, wrap, full saturation
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd255, 8'd128, 8'd127);
        send_pixel(8'd127, 8'd255, 8'd128);
        send_pixel(8'd128, 8'd127, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd85,  8'd170, 8'd0);
        send_pixel(8'd10,  8'd200, 8'd250);
        send_pixel(8'd255, 8'd254, 8'd254);

        random_pixels(RAND_PIXELS);
        i_start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes
        waited = 0;
        while (sb.pending_hsv.size() != 0 && waited < 10 * DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.pending_hsv.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending_hsv.size());
        end

        $display("Converted %0d pixels (%0d gray, %0d black) and checked %0d results.",
                 sb.requests, sb.gray_seen, sb.black_seen, sb.results);
        $display("Mismatches and stray or missing results: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
